// ===== rtl/lfww_pkg.sv =====
// ----------------------------------------------------------------------------
// Line fold word wrap package
// Shared constants, item and status types, and the engine state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package lfww_pkg;

  localparam int unsigned MaxWidth   = 32;
  localparam int unsigned BufAw      = $clog2(MaxWidth);
  localparam int unsigned CntW       = $clog2(MaxWidth + 1);
  localparam int unsigned CharW      = 8;

  // The queue depth must be a power of two so that the pointers wrap freely.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [CharW-1:0] BlankCh   = 8'h20;
  localparam logic [CharW-1:0] HyphenCh  = 8'h2D;
  localparam logic [CharW-1:0] NewlineCh = 8'h0A;

  localparam logic [CntW-1:0] WidthReset = CntW'(12);
  localparam logic [CntW-1:0] WidthMin   = CntW'(3);
  localparam logic [CntW-1:0] WidthMax   = CntW'(MaxWidth);

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             line_end;
    logic             is_blank;
  } item_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
  } front_stat_t;

  typedef struct packed {
    logic [CntW-1:0]  fill;
    logic [BufAw-1:0] blank_pos;
  } back_stat_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_BREAK = 5'b00010,
    S_HYPH  = 5'b00100,
    S_NL    = 5'b01000,
    S_FLUSH = 5'b10000
  } eng_state_e;

endpackage

`default_nettype wire

// ===== rtl/lfww_front.sv =====
// ----------------------------------------------------------------------------
// Line fold word wrap front end
// Accepts characters, marks break blanks and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lfww_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [lfww_pkg::CharW-1:0]    ch_i,
  input  wire logic                          line_end_i,
  input  wire logic                          pop_i,
  output      logic                          item_valid_o,
  output      lfww_pkg::item_t               item_o,
  output      lfww_pkg::front_stat_t         status_o
);

  lfww_pkg::item_t                   mem_q [lfww_pkg::QueueDepth];
  logic [lfww_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [lfww_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [lfww_pkg::QCntW-1:0]        count_q, count_d;
  logic                              push, pop;
  lfww_pkg::item_t                   new_item;

  assign in_ready_o   = (count_q != lfww_pkg::QCntW'(lfww_pkg::QueueDepth));
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign status_o.count = count_q;

  assign push = in_valid_i && in_ready_o;
  assign pop  = pop_i && item_valid_o;

  always_comb begin
    new_item.ch       = ch_i;
    new_item.line_end = line_end_i;
    new_item.is_blank = (ch_i == lfww_pkg::BlankCh);
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lfww_back.sv =====
// ----------------------------------------------------------------------------
// Line fold word wrap engine
// Keeps the segment in a ring buffer, breaks and flushes it, and drives the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfww_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lfww_pkg::CntW-1:0]     cfg_wdata_i,
  input  wire logic                          item_valid_i,
  input  wire lfww_pkg::item_t               item_i,
  output      logic                          pop_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [lfww_pkg::CharW-1:0]    out_char_o,
  output      logic                          run_last_o,
  output      lfww_pkg::back_stat_t          status_o
);

  localparam int unsigned Aw = lfww_pkg::BufAw;
  localparam int unsigned Cw = lfww_pkg::CntW;

  logic [lfww_pkg::CharW-1:0] buf_q [lfww_pkg::MaxWidth];

  lfww_pkg::eng_state_e       state_q, state_d;
  logic [Cw-1:0]              width_q, width_d;
  logic [Aw-1:0]              head_q, head_d;
  logic [Cw-1:0]              fill_q, fill_d;
  logic [Aw-1:0]              lbp_q, lbp_d;
  logic [Cw-1:0]              idx_q, idx_d;
  logic [Cw-1:0]              cnt_q, cnt_d;
  logic                       brk_blank_q, brk_blank_d;
  lfww_pkg::item_t            cur_q, cur_d;

  logic                       out_valid_q;
  logic [lfww_pkg::CharW-1:0] out_char_q;
  logic                       out_last_q;

  logic                       slot_free;
  logic                       emit;
  logic [lfww_pkg::CharW-1:0] emit_char;
  logic                       emit_last;
  logic [lfww_pkg::CharW-1:0] rd_data_q;
  logic [Aw-1:0]              rd_addr;

  logic                       do_append;
  logic [Aw-1:0]              app_head;
  logic [Cw-1:0]              app_fill;
  logic [Aw-1:0]              app_lbp;
  lfww_pkg::item_t            app_item;
  logic                       buf_we;
  logic [Aw-1:0]              wr_addr;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_last_o  = out_last_q;
  assign status_o.fill      = fill_q;
  assign status_o.blank_pos = lbp_q;

  always_comb begin
    width_d = width_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i < lfww_pkg::WidthMin) begin
        width_d = lfww_pkg::WidthMin;
      end else if (cfg_wdata_i > lfww_pkg::WidthMax) begin
        width_d = lfww_pkg::WidthMax;
      end else begin
        width_d = cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    lbp_d       = lbp_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    brk_blank_d = brk_blank_q;
    cur_d       = cur_q;
    pop_o       = 1'b0;
    emit        = 1'b0;
    emit_char   = rd_data_q;
    emit_last   = 1'b0;
    do_append   = 1'b0;
    app_head    = head_q;
    app_fill    = fill_q;
    app_lbp     = lbp_q;
    app_item    = item_i;
    buf_we      = 1'b0;
    wr_addr     = '0;

    unique case (state_q)
      lfww_pkg::S_IDLE: begin
        pop_o = item_valid_i;
        if (item_valid_i) begin
          if (fill_q >= width_q) begin
            cur_d       = item_i;
            brk_blank_d = (lbp_q != '0);
            cnt_d       = (lbp_q != '0) ? {1'b0, lbp_q} : fill_q - Cw'(2);
            idx_d       = '0;
            state_d     = lfww_pkg::S_BREAK;
          end else begin
            do_append = 1'b1;
          end
        end
      end
      lfww_pkg::S_BREAK: begin
        if (slot_free) begin
          emit  = 1'b1;
          idx_d = idx_q + 1'b1;
          if (idx_q == cnt_q - Cw'(1)) begin
            state_d = brk_blank_q ? lfww_pkg::S_NL : lfww_pkg::S_HYPH;
          end
        end
      end
      lfww_pkg::S_HYPH: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = lfww_pkg::HyphenCh;
          state_d   = lfww_pkg::S_NL;
        end
      end
      lfww_pkg::S_NL: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = lfww_pkg::NewlineCh;
          emit_last = !cur_q.line_end;
          do_append = 1'b1;
          app_item  = cur_q;
          app_lbp   = '0;
          if (brk_blank_q) begin
            app_head = head_q + lbp_q + 1'b1;
            app_fill = fill_q - Cw'(1) - {1'b0, lbp_q};
          end else begin
            app_head = head_q + fill_q[Aw-1:0] - Aw'(2);
            app_fill = Cw'(2);
          end
        end
      end
      lfww_pkg::S_FLUSH: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = (idx_q == fill_q - Cw'(1));
          idx_d     = idx_q + 1'b1;
          if (emit_last) begin
            fill_d  = '0;
            lbp_d   = '0;
            state_d = lfww_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = lfww_pkg::S_IDLE;
      end
    endcase

    if (do_append) begin
      buf_we  = 1'b1;
      wr_addr = app_head + app_fill[Aw-1:0];
      head_d  = app_head;
      fill_d  = app_fill + 1'b1;
      lbp_d   = (app_item.is_blank && app_fill != '0) ? app_fill[Aw-1:0] : app_lbp;
      idx_d   = '0;
      state_d = app_item.line_end ? lfww_pkg::S_FLUSH : lfww_pkg::S_IDLE;
    end

    rd_addr = head_d + idx_d[Aw-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfww_pkg::S_IDLE;
      width_q     <= lfww_pkg::WidthReset;
      head_q      <= '0;
      fill_q      <= '0;
      lbp_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      brk_blank_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      width_q     <= width_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      lbp_q       <= lbp_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      brk_blank_q <= brk_blank_d;
      if (slot_free) begin
        out_valid_q <= emit;
      end
    end
  end

  // The character written in this cycle is passed straight to the read
  // register when the next read points at the same entry.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
    end
    if (buf_we) begin
      buf_q[wr_addr] <= app_item.ch;
    end
    if (buf_we && (wr_addr == rd_addr)) begin
      rd_data_q <= app_item.ch;
    end else begin
      rd_data_q <= buf_q[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/line_fold_word_wrap_core.sv =====
// ----------------------------------------------------------------------------
// Line fold word wrap core
// Folds a character stream into segments of the configured width, breaking
// at the last blank or with a hyphen.
// ----------------------------------------------------------------------------
// Characters enter on the in channel (ch_i, line_end_i) with valid and ready,
// and leave on the out channel (out_char_o, run_last_o) one per transfer.
// run_last_o marks the final output character caused by one input character.
// A character that neither breaks nor ends a line causes no output.
// A two-entry queue holds incoming characters while the engine works.
// The engine appends each character to the segment.
// A break emits the segment up to its last blank, or all but its last two
// characters and a hyphen, then a newline, and appends the breaking character.
// A line end emits the whole segment at one character per cycle, and the
// output register passes one character per cycle, while the receiver is
// ready. The line width is written through cfg_we_i and cfg_wdata_i; the
// user must write it only while idle, which the block does not enforce.
// Values are clamped to 3..32. After reset the width is 12 and the segment
// is empty. When the receiver stalls, the output register holds its
// character, the engine waits, and the queue fills before in_ready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module line_fold_word_wrap_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lfww_pkg::CntW-1:0]     cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [lfww_pkg::CharW-1:0]    ch_i,
  input  wire logic                          line_end_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [lfww_pkg::CharW-1:0]    out_char_o,
  output      logic                          run_last_o
);

  lfww_pkg::item_t       item;
  logic                  item_valid;
  logic                  pop;
  lfww_pkg::front_stat_t front_stat;
  lfww_pkg::back_stat_t  back_stat;

  lfww_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ch_i         (ch_i),
    .line_end_i   (line_end_i),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item),
    .status_o     (front_stat)
  );

  lfww_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .run_last_o   (run_last_o),
    .status_o     (back_stat)
  );

  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_stat.count <= lfww_pkg::QCntW'(lfww_pkg::QueueDepth))
    else $error("Queue count exceeds its depth.");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.fill <= lfww_pkg::WidthMax)
    else $error("Segment fill exceeds the buffer size.");

  a_blank_in_segment : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_stat.blank_pos != '0) |-> ({1'b0, back_stat.blank_pos} < back_stat.fill))
    else $error("Break blank lies outside the segment.");

endmodule

`default_nettype wire
